@@ rtl/bpbc_pkg.sv @@
`default_nettype none
package bpbc_pkg;
  localparam int CHANNELS = 8;
  localparam int SYMS = 5;
  localparam int ENTRIES = CHANNELS * SYMS * SYMS;
  localparam int ADDR_BITS = 8;
  localparam int DEF_COUNT_BITS = 32;
  localparam int DEF_FRACTION_BITS = 16;
  localparam logic [15:0] WARMUP_RESET = 16'd200;
  localparam logic [2:0] PRIOR_RESET = 3'd2;
  localparam logic [15:0] PAIR_MAX = 16'hFFFF;

  function automatic logic [ADDR_BITS-1:0] entry_addr(input logic [2:0] ch,
      input logic [2:0] row, input logic [2:0] col);
    entry_addr = ADDR_BITS'(ch * 25 + row * 5 + col);
  endfunction
endpackage
`default_nettype wire

@@ rtl/bpbc_if.sv @@
`default_nettype none
interface bpbc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       stream_start;
  modport source(output valid, data_byte, stream_start, input ready);
  modport sink(input valid, data_byte, stream_start, output ready);
endinterface

interface bpbc_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] confidence;
  logic        warmed_up;
  modport source(output valid, confidence, warmed_up, input ready);
  modport sink(input valid, confidence, warmed_up, output ready);
endinterface
`default_nettype wire

@@ rtl/bpbc_divider.sv @@
`default_nettype none
module bpbc_divider
  import bpbc_pkg::*;
#(
  parameter int NUM_BITS = 48,
  parameter int DEN_BITS = 35
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic [NUM_BITS-1:0] num,
  input  wire logic [DEN_BITS-1:0] den,
  output logic                     done,
  output logic [NUM_BITS-1:0]      quo
);
  localparam int CNT_BITS = $clog2(NUM_BITS + 1);
  logic [NUM_BITS-1:0] n;
  logic [DEN_BITS-1:0] d;
  logic [DEN_BITS:0] rem;
  logic [CNT_BITS-1:0] cnt;
  logic busy;
  logic [DEN_BITS:0] trial;

  always_comb begin
    trial = {rem[DEN_BITS-1:0], n[NUM_BITS-1]};
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      n <= num;
      d <= den;
      rem <= '0;
      quo <= '0;
      cnt <= CNT_BITS'(NUM_BITS);
    end else if (busy) begin
      n <= {n[NUM_BITS-2:0], 1'b0};
      if (trial >= {1'b0, d}) begin
        rem <= trial - {1'b0, d};
        quo <= {quo[NUM_BITS-2:0], 1'b1};
      end else begin
        rem <= trial;
        quo <= {quo[NUM_BITS-2:0], 1'b0};
      end
      cnt <= cnt - 1'b1;
      if (cnt == CNT_BITS'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

@@ rtl/bit_pair_bigram_confidence_core.sv @@
`default_nettype none
// Channel     Direction  Content
// in_ch       sink       data_byte, stream_start
// out_ch      source     confidence, warmed_up
// cfg         write      warmup_pairs (cfg_we, cfg_wdata)
// A warm pair takes eight rounds, each reading one table row and running one serial
// division, then an update step per channel that reads and writes one entry. A cold
// pair skips the reads and divisions and goes straight to the updates.
// Reset and stream_start clear the table to a count of one in every entry.
// Input is taken only in the idle state, after the previous result has gone into the
// output register; that move waits while the register still holds an earlier result.
module bit_pair_bigram_confidence_core
  import bpbc_pkg::*;
#(
  parameter int COUNT_BITS = DEF_COUNT_BITS,
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  bpbc_in_if.sink          in_ch,
  bpbc_out_if.source       out_ch,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata
);
  localparam int TOT_BITS = COUNT_BITS + 3;
  localparam int NUM_BITS = COUNT_BITS + FRACTION_BITS;
  localparam int SUM_BITS = FRACTION_BITS + 3;
  localparam logic [COUNT_BITS-1:0] CMAX = '1;

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_READ, S_DIV, S_UPD, S_WR, S_OUT}
    state_t;
  state_t state;

  logic [COUNT_BITS-1:0] mem [ENTRIES];
  logic [ADDR_BITS-1:0] rd_addr, wr_addr;
  logic [COUNT_BITS-1:0] rd_data, wr_data;
  logic wr_en;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  logic [15:0] warmup;
  logic [7:0] last_byte;
  logic have_last;
  logic [2:0] prior [CHANNELS];
  logic [2:0] tok [CHANNELS];
  logic [15:0] pair_count;
  logic warm;
  logic [2:0] ch;
  logic [2:0] col;
  logic phase;
  logic [TOT_BITS-1:0] tot;
  logic [COUNT_BITS-1:0] best;
  logic [SUM_BITS-1:0] sum;
  logic [7:0] cur;
  logic [15:0] conf;
  logic div_start, div_done;
  logic [NUM_BITS-1:0] quo;
  logic [ADDR_BITS-1:0] clr_addr;
  logic out_valid;
  logic [15:0] out_conf;
  logic out_warm;

  bpbc_divider #(.NUM_BITS(NUM_BITS), .DEN_BITS(TOT_BITS)) u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .num({best, {FRACTION_BITS{1'b0}}}), .den(tot), .done(div_done), .quo(quo)
  );

  logic [2:0] tk_next [CHANNELS];
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      logic [2:0] ep, op, ec, oc;
      ep = {2'b0, last_byte[7-2*i]};
      op = {2'b0, last_byte[6-2*i]};
      ec = {2'b0, in_ch.data_byte[7-2*i]};
      oc = {2'b0, in_ch.data_byte[6-2*i]};
      tk_next[i] = ep + op + 3'd2 - ec - oc;
      tk_next[4+i] = ep + oc + 3'd2 - op - ec;
    end
  end

  logic [SUM_BITS-1:0] mean;
  always_comb begin
    mean = sum >> 3;
    conf = 16'({mean, 16'd0} >> FRACTION_BITS);
  end

  assign in_ch.ready = (state == S_IDLE);
  assign out_ch.valid = out_valid;
  assign out_ch.confidence = out_conf;
  assign out_ch.warmed_up = out_warm;

  always_comb begin
    wr_en = 1'b0;
    wr_addr = entry_addr(ch, prior[ch], tok[ch]);
    wr_data = (rd_data < CMAX) ? rd_data + 1'b1 : rd_data;
    if (state == S_CLEAR) begin
      wr_en = 1'b1;
      wr_addr = clr_addr;
      wr_data = COUNT_BITS'(1);
    end else if (state == S_WR) begin
      wr_en = 1'b1;
    end
    rd_addr = (state == S_UPD || state == S_WR) ? entry_addr(ch, prior[ch], tok[ch])
                                                 : entry_addr(ch, prior[ch], col);
  end

  always_ff @(posedge clk) begin
    div_start <= 1'b0;
    if (rst) begin
      state <= S_CLEAR;
      clr_addr <= '0;
      warmup <= WARMUP_RESET;
      have_last <= 1'b0;
      last_byte <= '0;
      pair_count <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) prior[i] <= PRIOR_RESET;
    end else begin
      if (cfg_we) warmup <= cfg_wdata;
      if (out_ch.ready && state != S_OUT) out_valid <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == ADDR_BITS'(ENTRIES - 1)) begin
            state <= have_last ? S_IDLE : S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_ch.valid) begin
            cur <= in_ch.data_byte;
            if (in_ch.stream_start) begin
              have_last <= 1'b1;
              last_byte <= in_ch.data_byte;
              pair_count <= '0;
              for (int i = 0; i < CHANNELS; i++) prior[i] <= PRIOR_RESET;
              clr_addr <= '0;
              state <= S_CLEAR;
            end else if (!have_last) begin
              have_last <= 1'b1;
              last_byte <= in_ch.data_byte;
            end else begin
              for (int i = 0; i < CHANNELS; i++) tok[i] <= tk_next[i];
              warm <= pair_count >= warmup;
              ch <= '0;
              col <= '0;
              phase <= 1'b0;
              sum <= '0;
              tot <= '0;
              best <= '0;
              state <= (pair_count >= warmup) ? S_READ : S_UPD;
            end
          end
        end
        S_READ: begin
          if (!phase) begin
            phase <= 1'b1;
            col <= col + 1'b1;
          end else begin
            tot <= tot + TOT_BITS'(rd_data);
            if (rd_data > best) best <= rd_data;
            if (col == 3'd5) begin
              phase <= 1'b0;
              div_start <= 1'b1;
              state <= S_DIV;
            end else begin
              col <= col + 1'b1;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            sum <= sum + SUM_BITS'(quo);
            tot <= '0;
            best <= '0;
            col <= '0;
            if (ch == 3'd7) begin
              ch <= '0;
              state <= S_UPD;
            end else begin
              ch <= ch + 1'b1;
              state <= S_READ;
            end
          end
        end
        S_UPD: state <= S_WR;
        S_WR: begin
          prior[ch] <= tok[ch];
          if (ch == 3'd7) begin
            if (pair_count != PAIR_MAX) pair_count <= pair_count + 1'b1;
            last_byte <= cur;
            state <= S_OUT;
          end else begin
            ch <= ch + 1'b1;
            state <= S_UPD;
          end
        end
        S_OUT: begin
          if (!out_valid || out_ch.ready) begin
            out_valid <= 1'b1;
            out_conf <= warm ? conf : 16'd0;
            out_warm <= warm;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ sim/bit_pair_bigram_confidence_core_tb.sv @@
module bit_pair_bigram_confidence_core_tb;
  import bpbc_pkg::*;

  typedef struct {
    logic [7:0]  data_byte;
    logic        stream_start;
    logic        check_fixed;
    logic [15:0] fixed_conf;
    logic        fixed_warm;
  } stim_row_t;

  typedef struct {
    logic [15:0] conf;
    logic        warm;
  } conf_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;

  bpbc_in_if in_ch();
  bpbc_out_if out_ch();

  bit_pair_bigram_confidence_core dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  // Predictor state.
  logic [15:0] warmup_reg;
  logic [7:0]  prev_byte;
  logic        prev_valid;
  logic [31:0] bigram_tab [ENTRIES];
  logic [2:0]  prev_tok [CHANNELS];
  logic [15:0] pairs_seen;

  conf_result_t conf_queue[$];
  int fail_count = 0;
  int result_count = 0;
  int warm_count = 0;
  int idle_cycles = 0;
  bit no_gaps = 1'b0;

  function automatic void clear_predictor();
    for (int i = 0; i < ENTRIES; i++) bigram_tab[i] = 32'd1;
    for (int i = 0; i < CHANNELS; i++) prev_tok[i] = PRIOR_RESET;
    pairs_seen = '0;
    prev_byte = '0;
    prev_valid = 1'b0;
  endfunction

  function automatic void predict_pair(input logic [7:0] cur, input logic restart,
      input logic check_fixed, input logic [15:0] fconf, input logic fwarm);
    logic [2:0] tok [CHANNELS];
    logic [63:0] q_sum;
    logic [63:0] row_total;
    logic [63:0] row_best;
    logic [31:0] v;
    int base;
    int ep, op, ec, oc, sh;
    conf_result_t res;
    if (restart) clear_predictor();
    if (!prev_valid) begin
      prev_byte = cur;
      prev_valid = 1'b1;
      return;
    end
    for (int i = 0; i < 4; i++) begin
      sh = 6 - 2 * i;
      ep = prev_byte[sh+1];
      op = prev_byte[sh];
      ec = cur[sh+1];
      oc = cur[sh];
      tok[i] = 3'(ep + op + 2 - ec - oc);
      tok[4+i] = 3'(ep + oc + 2 - op - ec);
    end
    res.warm = (pairs_seen >= warmup_reg);
    res.conf = '0;
    if (res.warm) begin
      q_sum = '0;
      for (int ch = 0; ch < CHANNELS; ch++) begin
        base = ch * 25 + prev_tok[ch] * 5;
        row_total = '0;
        row_best = '0;
        for (int j = 0; j < SYMS; j++) begin
          v = bigram_tab[base + j];
          row_total += v;
          if (v > row_best) row_best = v;
        end
        if (row_total != 0) q_sum += (row_best << 16) / row_total;
      end
      res.conf = 16'(q_sum / CHANNELS);
    end
    for (int ch = 0; ch < CHANNELS; ch++) begin
      base = ch * 25 + prev_tok[ch] * 5 + tok[ch];
      if (bigram_tab[base] != 32'hFFFF_FFFF) bigram_tab[base] += 1;
      prev_tok[ch] = tok[ch];
    end
    if (pairs_seen != PAIR_MAX) pairs_seen += 1;
    prev_byte = cur;
    if (check_fixed && (res.conf !== fconf || res.warm !== fwarm)) begin
      $display("%0t directed row disagrees: expected conf %0d warm %0d, predicted %0d %0d",
               $time, fconf, fwarm, res.conf, res.warm);
      fail_count++;
    end
    conf_queue.push_back(res);
  endfunction

  // Input side.
  initial begin
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    in_ch.stream_start = 1'b0;
    out_ch.ready = 1'b0;
  end

  task automatic send_byte(input logic [7:0] b, input logic s, input logic chk,
      input logic [15:0] fc, input logic fw);
    int gap;
    if (!no_gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 15);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.stream_start <= s;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_pair(b, s, chk, fc, fw);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (conf_queue.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  task automatic write_warmup(input logic [15:0] w);
    drain_results();
    cfg_we <= 1'b1;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_we <= 1'b0;
    warmup_reg = w;
  endtask

  // Output side: ready in random bursts, sampled at the edge.
  initial begin
    int burst;
    @(negedge rst);
    forever begin
      if (!no_gaps && $urandom_range(0, 2) == 0) begin
        out_ch.ready <= 1'b0;
        burst = $urandom_range(1, 15);
      end else begin
        out_ch.ready <= 1'b1;
        burst = $urandom_range(1, 20);
      end
      repeat (burst) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (conf_queue.size() == 0) begin
        $display("%0t unexpected transfer: conf %0d warm %0d", $time,
                 out_ch.confidence, out_ch.warmed_up);
        fail_count++;
      end else begin
        conf_result_t e;
        e = conf_queue.pop_front();
        if (out_ch.confidence !== e.conf) begin
          $display("%0t confidence: expected %0d, actual %0d", $time, e.conf,
                   out_ch.confidence);
          fail_count++;
        end
        if (out_ch.warmed_up !== e.warm) begin
          $display("%0t warmed_up: expected %0d, actual %0d", $time, e.warm,
                   out_ch.warmed_up);
          fail_count++;
        end
        result_count++;
        if (e.warm) warm_count++;
      end
    end
  end

  // Watchdog on cycles with no transfer on either side.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("[bit_pair_bigram_confidence_core] ERROR");
      $finish;
    end
  end

  stim_row_t directed [10] = '{
    '{8'h00, 1'b0, 1'b0, 16'd0, 1'b0},
    '{8'hFF, 1'b0, 1'b1, 16'd0, 1'b0},
    '{8'h00, 1'b0, 1'b1, 16'd0, 1'b0},
    '{8'hAA, 1'b0, 1'b0, 16'd0, 1'b0},
    '{8'h55, 1'b0, 1'b0, 16'd0, 1'b0},
    '{8'h55, 1'b1, 1'b0, 16'd0, 1'b0},
    '{8'h0F, 1'b0, 1'b1, 16'd0, 1'b0},
    '{8'hF0, 1'b0, 1'b0, 16'd0, 1'b0},
    '{8'h3C, 1'b0, 1'b0, 16'd0, 1'b0},
    '{8'hC3, 1'b0, 1'b0, 16'd0, 1'b0}
  };

  initial begin
    logic [7:0] b;
    int n;
    warmup_reg = WARMUP_RESET;
    clear_predictor();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i])
      send_byte(directed[i].data_byte, directed[i].stream_start, directed[i].check_fixed,
                directed[i].fixed_conf, directed[i].fixed_warm);

    // With no warmup the first pair after a restart sees uniform rows: 1/5.
    write_warmup(16'd0);
    send_byte(8'h12, 1'b1, 1'b0, 16'd0, 1'b0);
    send_byte(8'h34, 1'b0, 1'b1, 16'd13107, 1'b1);
    send_byte(8'hFF, 1'b0, 1'b0, 16'd0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0, 16'd0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0, 16'd0, 1'b0);

    write_warmup(16'hFFFF);
    for (int i = 0; i < 250; i++)
      send_byte(8'($urandom), ($urandom_range(0, 60) == 0), 1'b0, 16'd0, 1'b0);

    write_warmup(16'd3);
    for (int i = 0; i < 400; i++) begin
      // Repetitive runs push rows toward high confidence.
      b = ($urandom_range(0, 1) == 0) ? 8'($urandom) : 8'(i % 4 == 0 ? 8'hA5 : 8'h5A);
      send_byte(b, ($urandom_range(0, 80) == 0), 1'b0, 16'd0, 1'b0);
    end

    in_ch.valid <= 1'b0;
    while (conf_queue.size() != 0) @(posedge clk);
    write_warmup(16'd200);
    send_byte(8'h77, 1'b1, 1'b0, 16'd0, 1'b0);
    for (int i = 0; i < 450; i++)
      send_byte(8'($urandom), ($urandom_range(0, 300) == 0), 1'b0, 16'd0, 1'b0);

    write_warmup(16'(($urandom_range(0, 1) == 0) ? 1 : $urandom_range(2, 40)));
    no_gaps = 1'b1;
    n = 430;
    for (int i = 0; i < n; i++)
      send_byte(8'($urandom), ($urandom_range(0, 100) == 0), 1'b0, 16'd0, 1'b0);

    in_ch.valid <= 1'b0;
    while (conf_queue.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    $display("Checked %0d results, %0d of them warm, over several warmup settings",
             result_count, warm_count);
    $display("including restarts, zero and full warmup, and back-to-back bursts.");
    if (fail_count == 0 && conf_queue.size() == 0)
      $display("[bit_pair_bigram_confidence_core] OK");
    else
      $display("[bit_pair_bigram_confidence_core] ERROR");
    $finish;
  end
endmodule
